FILE: design/grdda_pkg.sv
package grdda_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF = 640;
  localparam int unsigned MAP_SIDE_MAX_DEF = 64;

  localparam logic [27:0] DIST_MAX = 28'hFFF_FFFF;

  localparam logic [2:0] REG_POS_X      = 3'd0;
  localparam logic [2:0] REG_POS_Y      = 3'd1;
  localparam logic [2:0] REG_DIR_X      = 3'd2;
  localparam logic [2:0] REG_DIR_Y      = 3'd3;
  localparam logic [2:0] REG_PLANE_X    = 3'd4;
  localparam logic [2:0] REG_PLANE_Y    = 3'd5;
  localparam logic [2:0] REG_MAP_WIDTH  = 3'd6;
  localparam logic [2:0] REG_MAP_HEIGHT = 3'd7;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_CAST  = 1'b1;

  typedef struct packed {
    logic [23:0]        pos_x;
    logic [23:0]        pos_y;
    logic signed [17:0] dir_x;
    logic signed [17:0] dir_y;
    logic signed [17:0] plane_x;
    logic signed [17:0] plane_y;
    logic [6:0]         map_width;
    logic [6:0]         map_height;
  } cfg_t;

  typedef struct packed {
    logic        hit;
    logic        side;
    logic [7:0]  end_x;
    logic [7:0]  end_y;
    logic [27:0] wall_distance;
  } res_t;

endpackage

FILE: design/grdda_div.sv
module grdda_div #(
  parameter int unsigned NUM_W = 33,
  parameter int unsigned DEN_W = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] n_q, n_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             qbit;

  always_comb begin
    trial = {rem_q, n_q[NUM_W-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
    n_d   = {n_q[NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      n_q   <= n_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = n_q;

endmodule

FILE: design/grdda_map.sv
module grdda_map #(
  parameter int unsigned MAP_SIDE_MAX = grdda_pkg::MAP_SIDE_MAX_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic [2*$clog2(MAP_SIDE_MAX)-1:0]    wr_addr_i,
  input  logic                                 wr_data_i,
  input  logic [2*$clog2(MAP_SIDE_MAX)-1:0]    rd_addr_i,
  output logic                                 rd_data_o,
  output logic                                 busy_o
);

  localparam int unsigned ADDR_W = 2 * $clog2(MAP_SIDE_MAX);
  localparam int unsigned DEPTH  = 1 << ADDR_W;

  logic             mem_q [DEPTH];
  logic [ADDR_W:0]  clr_q;
  logic             rd_q;
  logic             clearing;

  assign clearing = ~clr_q[ADDR_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clearing) begin
      clr_q <= clr_q + (ADDR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing) begin
      mem_q[clr_q[ADDR_W-1:0]] <= 1'b0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;
  assign busy_o    = clearing;

endmodule

FILE: design/grdda_cast.sv
module grdda_cast #(
  parameter int unsigned SCREEN_WIDTH = grdda_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned MAP_SIDE_MAX = grdda_pkg::MAP_SIDE_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [9:0]                        column_i,
  input  grdda_pkg::cfg_t                   cfg_i,
  output logic [2*$clog2(MAP_SIDE_MAX)-1:0] rd_addr_o,
  input  logic                              rd_data_i,
  output logic                              res_valid_o,
  output grdda_pkg::res_t                   res_o,
  input  logic                              res_ack_i,
  output logic                              idle_o
);

  localparam int unsigned AW = $clog2(MAP_SIDE_MAX);

  // Reciprocal of the screen width, exact for every 10-bit column.
  localparam int unsigned CAM_K  = 27 + $clog2(SCREEN_WIDTH);
  localparam int unsigned CAM_SH = CAM_K - 17;
  localparam logic [28:0] CAM_M  = 29'(((64'd1 << CAM_K) + 64'(SCREEN_WIDTH) - 64'd1)
                                       / 64'(SCREEN_WIDTH));

  typedef enum logic [3:0] {
    S_IDLE, S_CAM, S_CAMQ, S_MULX, S_RAYX, S_RAYY, S_DIVX, S_DIVY,
    S_SDX, S_SDY, S_SDI, S_STEP, S_LOOK, S_CHK, S_FIN
  } state_e;

  state_e              state_q;
  logic [9:0]          col_q;
  logic signed [28:0]  cam_q;
  logic signed [29:0]  rx_q, ry_q;
  logic [27:0]         dx_q, dy_q;
  logic [15:0]         fx_q, fy_q;
  logic [9:0]          mx_q, my_q;
  logic [39:0]         distx_q, disty_q;
  logic signed [57:0]  prod_q;
  logic                side_q, hit_q;

  logic                div_start, div_done;
  logic [32:0]         div_num, div_quo;
  logic [29:0]         div_den;
  logic [27:0]         quo_sat;
  logic signed [28:0]  mul_a, mul_b;
  logic [57:0]         cam_quo;
  logic [16:0]         fterm_x, fterm_y;
  logic [24:0]         offx, offy;
  logic [9:0]          w10, h10;
  logic                outside;
  logic [39:0]         perp;

  grdda_div #(.NUM_W(33), .DEN_W(30)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    offx    = 25'(cfg_i.pos_x) + 25'd32768;
    offy    = 25'(cfg_i.pos_y) + 25'd32768;
    quo_sat = (div_quo > 33'(grdda_pkg::DIST_MAX)) ? grdda_pkg::DIST_MAX : div_quo[27:0];
    cam_quo = prod_q >> CAM_SH;
    fterm_x = rx_q[29] ? {1'b0, fx_q} : 17'd65536 - {1'b0, fx_q};
    fterm_y = ry_q[29] ? {1'b0, fy_q} : 17'd65536 - {1'b0, fy_q};
    w10 = (10'(cfg_i.map_width) > 10'(MAP_SIDE_MAX)) ? 10'(MAP_SIDE_MAX)
                                                      : 10'(cfg_i.map_width);
    h10 = (10'(cfg_i.map_height) > 10'(MAP_SIDE_MAX)) ? 10'(MAP_SIDE_MAX)
                                                       : 10'(cfg_i.map_height);
    outside = mx_q[9] || my_q[9] || (mx_q >= w10) || (my_q >= h10);
    perp = side_q ? disty_q - 40'(dy_q) : distx_q - 40'(dx_q);

    div_start = 1'b0;
    div_num   = 33'h1_0000_0000;
    div_den   = rx_q[29] ? 30'(-rx_q) : 30'(rx_q);
    case (state_q)
      S_RAYY: div_start = 1'b1;
      S_DIVX: begin
        div_start = div_done;
        div_den   = ry_q[29] ? 30'(-ry_q) : 30'(ry_q);
      end
      default: ;
    endcase

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_CAM: begin
        mul_a = $signed({19'd0, col_q});
        mul_b = $signed(CAM_M);
      end
      S_MULX: begin
        mul_a = $signed({{11{cfg_i.plane_x[17]}}, cfg_i.plane_x});
        mul_b = cam_q;
      end
      S_RAYX: begin
        mul_a = $signed({{11{cfg_i.plane_y[17]}}, cfg_i.plane_y});
        mul_b = cam_q;
      end
      S_SDX: begin
        mul_a = $signed({12'd0, fterm_x});
        mul_b = $signed({1'b0, dx_q});
      end
      S_SDY: begin
        mul_a = $signed({12'd0, fterm_y});
        mul_b = $signed({1'b0, dy_q});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      hit_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: if (start_i) begin
          hit_q   <= 1'b0;
          state_q <= S_CAM;
        end
        S_CAM:  state_q <= S_CAMQ;
        S_CAMQ: state_q <= S_MULX;
        S_MULX: state_q <= S_RAYX;
        S_RAYX: state_q <= S_RAYY;
        S_RAYY: state_q <= S_DIVX;
        S_DIVX: if (div_done) state_q <= S_DIVY;
        S_DIVY: if (div_done) state_q <= S_SDX;
        S_SDX:  state_q <= S_SDY;
        S_SDY:  state_q <= S_SDI;
        S_SDI:  state_q <= S_STEP;
        S_STEP: state_q <= S_LOOK;
        S_LOOK: state_q <= outside ? S_FIN : S_CHK;
        S_CHK: begin
          if (rd_data_i) begin
            hit_q   <= 1'b1;
            state_q <= S_FIN;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_FIN:  if (res_ack_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      S_IDLE: begin
        col_q <= column_i;
        mx_q  <= 10'(offx[24:16]);
        my_q  <= 10'(offy[24:16]);
        fx_q  <= offx[15:0];
        fy_q  <= offy[15:0];
      end
      S_CAMQ: cam_q <= $signed(cam_quo[28:0]) - 29'sd65536;
      S_RAYX: rx_q <= $signed({{12{cfg_i.dir_x[17]}}, cfg_i.dir_x}) + prod_q[45:16];
      S_RAYY: ry_q <= $signed({{12{cfg_i.dir_y[17]}}, cfg_i.dir_y}) + prod_q[45:16];
      S_DIVX: if (div_done) dx_q <= quo_sat;
      S_DIVY: if (div_done) dy_q <= quo_sat;
      S_SDY:  distx_q <= 40'(prod_q[45:16]);
      S_SDI:  disty_q <= 40'(prod_q[45:16]);
      S_STEP: begin
        if (distx_q < disty_q) begin
          distx_q <= distx_q + 40'(dx_q);
          mx_q    <= rx_q[29] ? mx_q - 10'd1 : mx_q + 10'd1;
          side_q  <= 1'b0;
        end else begin
          disty_q <= disty_q + 40'(dy_q);
          my_q    <= ry_q[29] ? my_q - 10'd1 : my_q + 10'd1;
          side_q  <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rd_addr_o   = {my_q[AW-1:0], mx_q[AW-1:0]};
  assign res_valid_o = (state_q == S_FIN);
  assign idle_o      = (state_q == S_IDLE);

  always_comb begin
    res_o.hit           = hit_q;
    res_o.side          = side_q;
    res_o.end_x         = mx_q[7:0];
    res_o.end_y         = my_q[7:0];
    res_o.wall_distance = (perp > 40'(grdda_pkg::DIST_MAX)) ? grdda_pkg::DIST_MAX
                                                             : perp[27:0];
  end

endmodule

FILE: design/grid_raycast_dda_core.sv
// Channel    Direction  Payload
// s_axis     in         tuser: mode; tdata: column, cell_x, cell_y, wall
// m_axis     out        tdata: hit, side, end_x, end_y, wall_distance
// apb        in         eight configuration registers at byte address 4*i
//
// A map write is done on the transfer that carries it. A cast runs a setup
// of camera and ray multiplies and two passes through the serial divider,
// then walks the grid cell by cell (step, map read, check); the step that
// leaves the map skips the check. The result then goes to the output register.
// After reset the map is cleared one cell per cycle, all 4096 cells at the
// default size, and s_axis_tready stays low until that is done.
// A finished result waits in the output register; a new item is taken
// meanwhile, but a second result waits in the engine until the first transfer.
module grid_raycast_dda_core #(
  parameter int unsigned SCREEN_WIDTH = grdda_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned MAP_SIDE_MAX = grdda_pkg::MAP_SIDE_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // column, cell_x, cell_y, wall, zero pad
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // hit, side, end_x, end_y, wall_distance, pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = $clog2(MAP_SIDE_MAX);

  grdda_pkg::cfg_t cfg_q;
  grdda_pkg::res_t res, out_q;
  logic            out_valid_q;
  logic            res_valid, res_ack, idle, map_busy;
  logic            s_acc, cast_start, wr_en, cfg_wr;
  logic [2*AW-1:0] wr_addr, rd_addr;
  logic            rd_data;
  logic [8:0]      cx9, cy9;
  logic [7:0]      cx8, cy8;

  assign pready        = 1'b1;
  assign s_axis_tready = idle & ~map_busy;
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign cast_start    = s_acc & (s_axis_tuser == grdda_pkg::MODE_CAST);
  assign cx9           = {3'd0, s_axis_tdata[15:10]};
  assign cy9           = {3'd0, s_axis_tdata[21:16]};
  assign cx8           = cx9[7:0];
  assign cy8           = cy9[7:0];
  assign wr_en         = s_acc & (s_axis_tuser == grdda_pkg::MODE_WRITE)
                         & (cx9 < 9'(MAP_SIDE_MAX)) & (cy9 < 9'(MAP_SIDE_MAX));
  assign wr_addr       = {cy8[AW-1:0], cx8[AW-1:0]};
  assign res_ack       = res_valid & ~out_valid_q;
  assign cfg_wr        = psel & penable & pwrite & pready;

  grdda_map #(.MAP_SIDE_MAX(MAP_SIDE_MAX)) u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (s_axis_tdata[22]),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .busy_o    (map_busy)
  );

  grdda_cast #(.SCREEN_WIDTH(SCREEN_WIDTH), .MAP_SIDE_MAX(MAP_SIDE_MAX)) u_cast (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cast_start),
    .column_i    (s_axis_tdata[9:0]),
    .cfg_i       (cfg_q),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ack_i   (res_ack),
    .idle_o      (idle)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_x      <= '0;
      cfg_q.pos_y      <= '0;
      cfg_q.dir_x      <= 18'sd65536;
      cfg_q.dir_y      <= '0;
      cfg_q.plane_x    <= '0;
      cfg_q.plane_y    <= 18'sd43254;
      cfg_q.map_width  <= 7'd64;
      cfg_q.map_height <= 7'd64;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        grdda_pkg::REG_POS_X:      cfg_q.pos_x      <= pwdata[23:0];
        grdda_pkg::REG_POS_Y:      cfg_q.pos_y      <= pwdata[23:0];
        grdda_pkg::REG_DIR_X:      cfg_q.dir_x      <= $signed(pwdata[17:0]);
        grdda_pkg::REG_DIR_Y:      cfg_q.dir_y      <= $signed(pwdata[17:0]);
        grdda_pkg::REG_PLANE_X:    cfg_q.plane_x    <= $signed(pwdata[17:0]);
        grdda_pkg::REG_PLANE_Y:    cfg_q.plane_y    <= $signed(pwdata[17:0]);
        grdda_pkg::REG_MAP_WIDTH:  cfg_q.map_width  <= pwdata[6:0];
        grdda_pkg::REG_MAP_HEIGHT: cfg_q.map_height <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      grdda_pkg::REG_POS_X:      prdata = 32'(cfg_q.pos_x);
      grdda_pkg::REG_POS_Y:      prdata = 32'(cfg_q.pos_y);
      grdda_pkg::REG_DIR_X:      prdata = 32'(unsigned'(cfg_q.dir_x));
      grdda_pkg::REG_DIR_Y:      prdata = 32'(unsigned'(cfg_q.dir_y));
      grdda_pkg::REG_PLANE_X:    prdata = 32'(unsigned'(cfg_q.plane_x));
      grdda_pkg::REG_PLANE_Y:    prdata = 32'(unsigned'(cfg_q.plane_y));
      grdda_pkg::REG_MAP_WIDTH:  prdata = 32'(cfg_q.map_width);
      grdda_pkg::REG_MAP_HEIGHT: prdata = 32'(cfg_q.map_height);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'd0, out_q.wall_distance, out_q.end_y, out_q.end_x,
                          out_q.side, out_q.hit};

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_busy |-> !s_axis_tready)
    else $error("item taken while map clear runs");

  a_cast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cast_start |=> !s_axis_tready)
    else $error("ready right after a cast was taken");

  a_hit_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.hit) |->
      ({1'b0, out_q.end_x} < 9'(MAP_SIDE_MAX) && {1'b0, out_q.end_y} < 9'(MAP_SIDE_MAX)))
    else $error("hit reported outside the map");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(res_valid))
    else $error("result register loaded without a finished cast");

endmodule
